@@ hdl/msp_pkg.sv @@
// Shared types, constants and sine table for the multichannel spread panner.
package msp_pkg;

    localparam int MAX_OUTPUTS      = 8;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
    localparam int HALF             = SINE_TABLE_DEPTH / 2;
    localparam int HB               = $clog2(HALF);
    localparam int KW               = HB + 1;
    localparam int LW               = $clog2(QUARTER + 1);
    localparam int NW               = $clog2(MAX_OUTPUTS + 1);
    localparam int JW               = $clog2(MAX_OUTPUTS);
    localparam int NH_W             = 11 + HB;
    localparam int CW               = 16 + KW;
    localparam int SUM_W            = 41;
    localparam int BASE_W           = ((33 + NW) > 39 ? (33 + NW) : 39) + 1;
    localparam int HB_W             = BASE_W - 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QAW              = $clog2(QUEUE_DEPTH);
    localparam int SPREAD_MIN       = 26;

    localparam logic signed [62:0] INV_TWO_PI_Q32 = 63'sd683565276;
    localparam logic [63:0]        HALF_PI_Q30    = 64'd1686629713;
    localparam logic [63:0]        ONE_Q30        = 64'd1 << 30;

    typedef enum logic [2:0] {
        REG_NUM_OUTPUTS = 3'd0,
        REG_OPEN_LAYOUT = 3'd1,
        REG_ANGLE_RAD   = 3'd2,
        REG_OFFSET      = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [23:0] sample_in;
        logic signed [15:0] gain;
        logic signed [31:0] position;
        logic signed [15:0] spread;
    } msp_in_t;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic [2:0]         output_index;
        logic               last;
    } msp_out_t;

    typedef struct packed {
        logic signed [23:0] smp;
        logic signed [15:0] g;
        logic [14:0]        s;
        logic [NW-1:0]      n;
        logic [JW-1:0]      r0;
        logic [31:0]        low;
    } msp_job_t;

    typedef struct packed {
        logic               last;
        logic [JW-1:0]      j;
        logic signed [23:0] smp;
        logic signed [15:0] g;
        logic               inr;
    } msp_tag_t;

    typedef logic [30:0] sine_lut_t [0:QUARTER];

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t   lut;
        logic [63:0] u;
        logic [63:0] th;
        logic [63:0] t2;
        logic [63:0] r;
        for (int k = 0; k <= QUARTER; k++)
        begin
            u  = (64'(k) << 30) / 64'(QUARTER);
            th = (u * HALF_PI_Q30) >> 30;
            t2 = (th * th) >> 30;
            r  = ONE_Q30 - t2 / 64'd156;
            r  = ONE_Q30 - ((t2 * r) >> 30) / 64'd110;
            r  = ONE_Q30 - ((t2 * r) >> 30) / 64'd72;
            r  = ONE_Q30 - ((t2 * r) >> 30) / 64'd42;
            r  = ONE_Q30 - ((t2 * r) >> 30) / 64'd20;
            r  = ONE_Q30 - ((t2 * r) >> 30) / 64'd6;
            r  = (th * r) >> 30;
            lut[k] = (r > ONE_Q30) ? 31'(ONE_Q30) : 31'(r);
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

@@ hdl/multichannel_spread_panner.sv @@
// Top level of the multichannel spread panner.
// The back end produces one output per cycle unless out_ready holds it, and an item
// occupies it for as many outputs as are in use (10-stage phase divider, sine table,
// two multiply stages).
// A 4-entry job queue lets the front end keep taking items while the back end stalls, until it fills.
// Reset: asynchronous active-low; clears pipelines and queue, loads register defaults.
module multichannel_spread_panner
    import msp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  msp_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output msp_out_t    out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic     f_valid, f_ready, q_valid, q_ready;
    msp_job_t f_job, q_job;

    msp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    msp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_job)
    );

    msp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ hdl/msp_front.sv @@
// Front end: configuration registers, position wrap and per-item job setup.
module msp_front
    import msp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  msp_in_t     in_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output logic        job_valid,
    input  logic        job_ready,
    output msp_job_t    job
);

    logic [3:0]  num_outputs_reg;
    logic        open_reg;
    logic        rad_reg;
    logic [15:0] offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_outputs_reg <= 4'd2;
            open_reg        <= 1'b0;
            rad_reg         <= 1'b0;
            offset_reg      <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_OUTPUTS: num_outputs_reg <= cfg_wdata[3:0];
                REG_OPEN_LAYOUT: open_reg        <= cfg_wdata[0];
                REG_ANGLE_RAD:   rad_reg         <= cfg_wdata[0];
                REG_OFFSET:      offset_reg      <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // stage 1
    logic                f1_valid_reg;
    logic signed [23:0]  f1_smp_reg;
    logic signed [15:0]  f1_g_reg;
    logic signed [31:0]  f1_pos_reg;
    logic signed [62:0]  f1_prod_reg;
    logic [14:0]         f1_s_reg;
    logic [NW-1:0]       f1_n_reg;
    logic [NW-1:0]       f1_m_reg;
    logic                f1_rad_reg;
    logic [15:0]         f1_off_reg;
    // stage 2
    logic                f2_valid_reg;
    logic signed [23:0]  f2_smp_reg;
    logic signed [15:0]  f2_g_reg;
    logic [14:0]         f2_s_reg;
    logic [NW-1:0]       f2_n_reg;
    logic [31:0]         f2_low_reg;
    logic [HB_W-1:0]     f2_hb_reg;
    // stage 3
    logic                f3_valid_reg;
    logic signed [23:0]  f3_smp_reg;
    logic signed [15:0]  f3_g_reg;
    logic [14:0]         f3_s_reg;
    logic [NW-1:0]       f3_n_reg;
    logic [31:0]         f3_low_reg;
    logic [HB_W-1:0]     f3_hb_reg;

    logic f1_free, f2_free, f3_free;

    assign f3_free  = !f3_valid_reg || job_ready;
    assign f2_free  = !f2_valid_reg || f3_free;
    assign f1_free  = !f1_valid_reg || f2_free;
    assign in_ready = f1_free;

    logic [NW-1:0]      n_c;
    logic [14:0]        s_c;
    logic signed [62:0] prod_c;

    always_comb
    begin
        if (num_outputs_reg < 4'd2)
            n_c = NW'(2);
        else if (int'(num_outputs_reg) > MAX_OUTPUTS)
            n_c = NW'(MAX_OUTPUTS);
        else
            n_c = NW'(num_outputs_reg);
        if (in_data.spread < 16'sd26)
            s_c = 15'(SPREAD_MIN);
        else
            s_c = in_data.spread[14:0];
        prod_c = 63'(in_data.position) * INV_TWO_PI_Q32;
    end

    logic               neg_c;
    logic [62:0]        mag_c;
    logic [62:0]        rnd_c;
    logic signed [48:0] t_c;
    logic signed [48:0] tw_c;
    logic [32:0]        w_c;
    logic [BASE_W-1:0]  base_c;

    always_comb
    begin
        neg_c = f1_prod_reg[62];
        mag_c = neg_c ? 63'(-f1_prod_reg) : 63'(f1_prod_reg);
        rnd_c = (mag_c + (63'd1 << 15)) >> 16;
        if (f1_rad_reg)
            t_c = neg_c ? -$signed(49'(rnd_c)) : $signed(49'(rnd_c));
        else
            t_c = $signed({f1_pos_reg[31], f1_pos_reg, 16'd0});
        tw_c = t_c - $signed(49'({f1_off_reg, 16'd0}));
        if (tw_c[31:0] == 32'd0 && !tw_c[48] && tw_c != 49'sd0)
            w_c = 33'h1_0000_0000;
        else
            w_c = {1'b0, tw_c[31:0]};
        base_c = BASE_W'(w_c) * BASE_W'(f1_m_reg) + BASE_W'({f1_s_reg, 24'd0});
    end

    logic [NW:0] rem_c;

    always_comb
    begin
        rem_c = '0;
        for (int i = HB_W - 1; i >= 0; i--)
        begin
            rem_c = {rem_c[NW-1:0], f3_hb_reg[i]};
            if (rem_c >= {1'b0, f3_n_reg})
                rem_c = rem_c - {1'b0, f3_n_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else
        begin
            if (f1_free)
                f1_valid_reg <= in_valid;
            if (f2_free)
                f2_valid_reg <= f1_valid_reg;
            if (f3_free)
                f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_free && in_valid)
        begin
            f1_smp_reg  <= in_data.sample_in;
            f1_g_reg    <= in_data.gain;
            f1_pos_reg  <= in_data.position;
            f1_prod_reg <= prod_c;
            f1_s_reg    <= s_c;
            f1_n_reg    <= n_c;
            f1_m_reg    <= n_c - NW'(open_reg);
            f1_rad_reg  <= rad_reg;
            f1_off_reg  <= offset_reg;
        end
        if (f2_free && f1_valid_reg)
        begin
            f2_smp_reg <= f1_smp_reg;
            f2_g_reg   <= f1_g_reg;
            f2_s_reg   <= f1_s_reg;
            f2_n_reg   <= f1_n_reg;
            f2_low_reg <= base_c[31:0];
            f2_hb_reg  <= base_c[BASE_W-1:32];
        end
        if (f3_free && f2_valid_reg)
        begin
            f3_smp_reg <= f2_smp_reg;
            f3_g_reg   <= f2_g_reg;
            f3_s_reg   <= f2_s_reg;
            f3_n_reg   <= f2_n_reg;
            f3_low_reg <= f2_low_reg;
            f3_hb_reg  <= f2_hb_reg;
        end
    end

    assign job_valid = f3_valid_reg;
    assign job.smp   = f3_smp_reg;
    assign job.g     = f3_g_reg;
    assign job.s     = f3_s_reg;
    assign job.n     = f3_n_reg;
    assign job.r0    = rem_c[JW-1:0];
    assign job.low   = f3_low_reg;

endmodule

@@ hdl/msp_queue.sv @@
// Short job queue between the front end and the output engine.
module msp_queue
    import msp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  msp_job_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output msp_job_t pop_data
);

    msp_job_t     mem [QUEUE_DEPTH];
    logic [QAW-1:0] wr_reg, rd_reg;
    logic [QAW:0]   count_reg;
    logic           push, pop;

    assign push_ready = (count_reg != (QAW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ hdl/msp_back.sv @@
// Output engine: per-output sequencer, phase divider, sine lookup and gain.
module msp_back
    import msp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  msp_job_t job,
    output logic     out_valid,
    input  logic     out_ready,
    output msp_out_t out_data
);

    logic          adv, emit, is_last;
    logic          cur_valid_reg;
    msp_job_t      cur_reg;
    logic [JW-1:0] j_reg, r_reg;
    logic          out_valid_reg;
    msp_out_t      out_data_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign emit      = adv && cur_valid_reg;
    assign is_last   = (NW'(j_reg) == cur_reg.n - 1'b1);
    assign job_ready = !cur_valid_reg || (emit && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_valid_reg <= 1'b0;
        else if (job_valid && job_ready)
            cur_valid_reg <= 1'b1;
        else if (emit && is_last)
            cur_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            cur_reg <= job;
            j_reg   <= '0;
            r_reg   <= job.r0;
        end
        else if (emit)
        begin
            j_reg <= j_reg + 1'b1;
            r_reg <= (r_reg == '0) ? JW'(cur_reg.n - 1'b1) : r_reg - 1'b1;
        end
    end

    logic [JW+31:0]  d_c;
    logic [SUM_W-1:0] sum_c;
    msp_tag_t        tag_c;

    always_comb
    begin
        d_c         = {r_reg, cur_reg.low};
        sum_c       = SUM_W'(d_c) + (SUM_W'(cur_reg.s) << (24 - HB));
        tag_c.last  = is_last;
        tag_c.j     = j_reg;
        tag_c.smp   = cur_reg.smp;
        tag_c.g     = cur_reg.g;
        tag_c.inr   = (SUM_W'(d_c) <= (SUM_W'(cur_reg.s) << 25));
    end

    logic            b0_valid_reg;
    msp_tag_t        b0_tag_reg;
    logic [14:0]     b0_s_reg;
    logic [NH_W-1:0] b0_rem_reg;

    logic            dv_valid_reg [KW];
    msp_tag_t        dv_tag_reg   [KW];
    logic [14:0]     dv_s_reg     [KW];
    logic [NH_W-1:0] dv_rem_reg   [KW];
    logic [KW-1:0]   dv_q_reg     [KW];

    logic            dv_valid_in [KW];
    msp_tag_t        dv_tag_in   [KW];
    logic [14:0]     dv_s_in     [KW];
    logic [NH_W-1:0] dv_rem_in   [KW];
    logic [KW-1:0]   dv_q_in     [KW];
    logic [NH_W-1:0] dv_rem_out  [KW];
    logic [KW-1:0]   dv_q_out    [KW];

    always_comb
    begin
        for (int i = 0; i < KW; i++)
        begin
            if (i == 0)
            begin
                dv_valid_in[i] = b0_valid_reg;
                dv_tag_in[i]   = b0_tag_reg;
                dv_s_in[i]     = b0_s_reg;
                dv_rem_in[i]   = b0_rem_reg;
                dv_q_in[i]     = '0;
            end
            else
            begin
                dv_valid_in[i] = dv_valid_reg[i-1];
                dv_tag_in[i]   = dv_tag_reg[i-1];
                dv_s_in[i]     = dv_s_reg[i-1];
                dv_rem_in[i]   = dv_rem_reg[i-1];
                dv_q_in[i]     = dv_q_reg[i-1];
            end
            if (CW'(dv_rem_in[i]) >= (CW'(dv_s_in[i]) << (KW - 1 - i)))
            begin
                dv_rem_out[i] = NH_W'(CW'(dv_rem_in[i]) - (CW'(dv_s_in[i]) << (KW - 1 - i)));
                dv_q_out[i]   = dv_q_in[i] | (KW'(1) << (KW - 1 - i));
            end
            else
            begin
                dv_rem_out[i] = dv_rem_in[i];
                dv_q_out[i]   = dv_q_in[i];
            end
        end
    end

    logic [KW-1:0] kc_c, kf_c;
    logic [30:0]   amp_c;

    always_comb
    begin
        kc_c  = (dv_q_reg[KW-1] > KW'(HALF)) ? KW'(HALF) : dv_q_reg[KW-1];
        kf_c  = (kc_c > KW'(QUARTER)) ? KW'(HALF) - kc_c : kc_c;
        amp_c = dv_tag_reg[KW-1].inr ? SINE_LUT[kf_c[LW-1:0]] : 31'd0;
    end

    logic               a_valid_reg, m1_valid_reg, m2_valid_reg;
    msp_tag_t           a_tag_reg, m1_tag_reg, m2_tag_reg;
    logic [30:0]        a_amp_reg;
    logic signed [55:0] m1_p_reg;
    logic signed [41:0] m2_p_reg;

    logic signed [55:0] p1_c;
    logic               neg1_c, neg2_c;
    logic [55:0]        mag1_c, rnd1_c;
    logic signed [25:0] v1_c;
    logic signed [41:0] p2_c;
    logic [41:0]        mag2_c, rnd2_c;
    logic signed [29:0] v2_c;
    logic signed [23:0] sat_c;

    always_comb
    begin
        p1_c   = 56'(a_tag_reg.smp) * 56'($signed({1'b0, a_amp_reg}));
        neg1_c = m1_p_reg[55];
        mag1_c = neg1_c ? 56'(-m1_p_reg) : 56'(m1_p_reg);
        rnd1_c = (mag1_c + (56'd1 << 29)) >> 30;
        v1_c   = neg1_c ? -$signed(26'(rnd1_c)) : $signed(26'(rnd1_c));
        p2_c   = 42'(v1_c) * 42'(m1_tag_reg.g);
        neg2_c = m2_p_reg[41];
        mag2_c = neg2_c ? 42'(-m2_p_reg) : 42'(m2_p_reg);
        rnd2_c = (mag2_c + (42'd1 << 11)) >> 12;
        v2_c   = neg2_c ? -$signed(30'(rnd2_c)) : $signed(30'(rnd2_c));
        if (v2_c > 30'sd8388607)
            sat_c = 24'sd8388607;
        else if (v2_c < -30'sd8388608)
            sat_c = -24'sd8388608;
        else
            sat_c = 24'(v2_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < KW; i++)
                dv_valid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            b0_valid_reg  <= emit;
            for (int i = 0; i < KW; i++)
                dv_valid_reg[i] <= dv_valid_in[i];
            a_valid_reg   <= dv_valid_reg[KW-1];
            m1_valid_reg  <= a_valid_reg;
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_tag_reg <= tag_c;
            b0_s_reg   <= cur_reg.s;
            b0_rem_reg <= NH_W'(sum_c >> (25 - HB));
            for (int i = 0; i < KW; i++)
            begin
                dv_tag_reg[i] <= dv_tag_in[i];
                dv_s_reg[i]   <= dv_s_in[i];
                dv_rem_reg[i] <= dv_rem_out[i];
                dv_q_reg[i]   <= dv_q_out[i];
            end
            a_tag_reg  <= dv_tag_reg[KW-1];
            a_amp_reg  <= amp_c;
            m1_tag_reg <= a_tag_reg;
            m1_p_reg   <= p1_c;
            m2_tag_reg <= m1_tag_reg;
            m2_p_reg   <= p2_c;
            out_data_reg.sample_out   <= sat_c;
            out_data_reg.output_index <= 3'(m2_tag_reg.j);
            out_data_reg.last         <= m2_tag_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_last_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        emit && is_last |=> b0_valid_reg && b0_tag_reg.last)
        else $error("final output of an item not tagged last");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> NW'(j_reg) < cur_reg.n)
        else $error("output counter beyond output count");

    a_last_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.last |-> out_data_reg.output_index != 3'd0)
        else $error("last flag on output zero");

endmodule
